>>> rtl/slirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slirs_pkg
// Shared codes and types for the sorted key table.
// ----------------------------------------------------------------------------
package slirs_pkg;

	localparam int KEY_W    = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	// broadcast from the control to every cell
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] key;
	} cell_ctrl_t;

endpackage

>>> rtl/slirs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slirs_cell
// One slot of the sorted table: holds a key, compares it with the broadcast
// key, and shifts toward or away from its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module slirs_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                            clk,
	input  slirs_pkg::cell_ctrl_t           ctrl,
	input  logic [CNT_W-1:0]                occ,
	input  logic                            prev_lt,
	input  logic signed [slirs_pkg::KEY_W-1:0] left_key,
	input  logic signed [slirs_pkg::KEY_W-1:0] right_key,
	output logic signed [slirs_pkg::KEY_W-1:0] key_q,
	output logic                            lt,
	output logic                            eq
);

	logic used;

	assign used = CNT_W'(IDX) < occ;
	assign lt   = used && (key_q < ctrl.key);
	assign eq   = used && (key_q == ctrl.key);

	// cells at or above the insertion / removal point move; lower ones hold
	always_ff @(posedge clk) begin
		if (!lt) begin
			if (ctrl.ins) begin
				key_q <= prev_lt ? ctrl.key : left_key;
			end else if (ctrl.rem) begin
				key_q <= right_key;
			end
		end
	end

endmodule

>>> rtl/sorted_list_insert_remove_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_search
// Ascending table of signed keys with insert, remove-first-match and search.
// ----------------------------------------------------------------------------
// The result strobe (done) comes in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, every cell compares the
//   key in the same cycle and shifts its neighbor's key on insert or remove.
// Reset: count of held keys cleared; key cells hold no reset value.
// The receiver cannot stall: done is high for a single cycle per result.
module sorted_list_insert_remove_search #(
	parameter int CAPACITY = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [slirs_pkg::FUNC_W-1:0]          func,
	input  logic signed [slirs_pkg::KEY_W-1:0]    key,
	output logic                                  done,
	output logic [slirs_pkg::STATUS_W-1:0]        status,
	output logic                                  found,
	output logic [slirs_pkg::COUNT_W-1:0]         entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]                       occ_q;
	logic                                   done_q;
	logic [slirs_pkg::STATUS_W-1:0]         status_q;
	logic                                   found_q;
	logic [slirs_pkg::COUNT_W-1:0]          count_q;

	logic signed [slirs_pkg::KEY_W-1:0]     cell_key [CAPACITY];
	logic [CAPACITY-1:0]                    cell_lt;
	logic [CAPACITY-1:0]                    cell_eq;

	slirs_pkg::cell_ctrl_t                  ctrl;
	logic                                   accept;
	logic                                   present;
	logic                                   full;
	logic [CNT_W-1:0]                       occ_n;
	logic [slirs_pkg::STATUS_W-1:0]         status_n;
	logic [CNT_W+slirs_pkg::COUNT_W-1:0]    occ_wide;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign present = |cell_eq;
	assign full    = occ_q == CNT_W'(CAPACITY);

	always_comb begin
		ctrl.key = key;
		ctrl.ins = 1'b0;
		ctrl.rem = 1'b0;
		occ_n    = occ_q;
		status_n = slirs_pkg::ST_DONE;
		if (func == slirs_pkg::FUNC_INSERT) begin
			if (full) begin
				status_n = slirs_pkg::ST_FULL;
			end else begin
				ctrl.ins = accept;
				occ_n    = occ_q + CNT_W'(1);
			end
		end else if (func == slirs_pkg::FUNC_REMOVE) begin
			if (!present) begin
				status_n = slirs_pkg::ST_NOT_FOUND;
			end else begin
				ctrl.rem = accept;
				occ_n    = occ_q - CNT_W'(1);
			end
		end
		// search and the unused code change nothing
	end

	assign occ_wide = {{slirs_pkg::COUNT_W{1'b0}}, occ_n};

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic                               prev_lt;
			logic signed [slirs_pkg::KEY_W-1:0] left_key;
			logic signed [slirs_pkg::KEY_W-1:0] right_key;

			if (gi == 0) begin : g_first
				assign prev_lt  = 1'b1;
				assign left_key = key;
			end else begin : g_mid
				assign prev_lt  = cell_lt[gi-1];
				assign left_key = cell_key[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_key = cell_key[gi];
			end else begin : g_inner
				assign right_key = cell_key[gi+1];
			end

			slirs_cell #(
				.IDX   (gi),
				.CNT_W (CNT_W)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ_q),
				.prev_lt   (prev_lt),
				.left_key  (left_key),
				.right_key (right_key),
				.key_q     (cell_key[gi]),
				.lt        (cell_lt[gi]),
				.eq        (cell_eq[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				occ_q <= occ_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_n;
			found_q  <= present;
			count_q  <= occ_wide[slirs_pkg::COUNT_W-1:0];
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_count = count_q;

endmodule

>>> bench/sorted_list_insert_remove_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_search_tb
// Self-checking bench for the sorted key table. A shadow table follows every
// accepted item and queues the expected status, found flag and entry count;
// each result strobe is checked against the oldest queued result. Directed
// items cover the empty and full table, duplicate keys and the extreme keys.
// Random phases then push the table up to full and back down to empty.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_search_tb;

	import slirs_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RANDOM_PHASES = 36;
	localparam int PHASE_ITEMS = 50;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [COUNT_W-1:0]  entry_count;
	} table_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [FUNC_W-1:0]        func = '0;
	logic signed [KEY_W-1:0]  key = '0;
	logic                     busy;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic                     found;
	logic [COUNT_W-1:0]       entry_count;

	logic signed [KEY_W-1:0]  shadow_keys[$];
	table_result_t            pending_results[$];
	int                       errors = 0;
	int                       burst_left = 1;

	sorted_list_insert_remove_search #(
		.CAPACITY(TABLE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.key        (key),
		.done       (done),
		.status     (status),
		.found      (found),
		.entry_count(entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the table: apply one operation, queue the result it must give.
	function automatic void predict_table_op(input logic [FUNC_W-1:0] op,
			input logic signed [KEY_W-1:0] k);
		int            pos;
		bit            present;
		table_result_t res;
		pos = 0;
		while (pos < shadow_keys.size() && shadow_keys[pos] < k)
			pos++;
		present = (pos < shadow_keys.size()) && (shadow_keys[pos] == k);
		res.status = ST_DONE;
		case (op)
			FUNC_INSERT: begin
				if (shadow_keys.size() >= TABLE_DEPTH)
					res.status = ST_FULL;
				else
					shadow_keys.insert(pos, k);
			end
			FUNC_REMOVE: begin
				if (!present)
					res.status = ST_NOT_FOUND;
				else
					shadow_keys.delete(pos);
			end
			default: ; // search and the unused code change nothing
		endcase
		res.found = present;
		res.entry_count = COUNT_W'(shadow_keys.size());
		pending_results.push_back(res);
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Check results first: the result is registered, so the strobe seen at an
	// edge belongs to an earlier item than the one accepted at that edge.
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual done %b",
						$time, done);
					errors++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", 8'(want.status), 8'(status));
					compare_field("found", 8'(want.found), 8'(found));
					compare_field("entry_count", 8'(want.entry_count), 8'(entry_count));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				predict_table_op(func, key);
		end
	end

	// Drive one item and hold it until accepted; idle between bursts.
	task automatic send_item(input logic [FUNC_W-1:0] op, input logic signed [KEY_W-1:0] k);
		start <= 1'b1;
		func  <= op;
		key   <= k;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			start <= 1'b0;
			key   <= $urandom(); // noise while idle must be ignored
			func  <= 2'($urandom());
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2, 3: return $urandom();
			4, 5: begin
				if (shadow_keys.size() != 0)
					return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
				return $urandom();
			end
			default: return $signed(KEY_W'($urandom_range(0, 12))) - 6;
		endcase
	endfunction

	task automatic test_empty_table();
		send_item(FUNC_SEARCH, 0);
		send_item(FUNC_REMOVE, 0);
		send_item(FUNC_UNUSED, KEY_MIN);
		send_item(FUNC_REMOVE, KEY_MAX);
	endtask

	task automatic test_extremes_and_duplicates();
		send_item(FUNC_INSERT, KEY_MAX);
		send_item(FUNC_INSERT, KEY_MIN);
		send_item(FUNC_INSERT, 0);
		send_item(FUNC_INSERT, 0);
		send_item(FUNC_INSERT, -1);
		send_item(FUNC_SEARCH, KEY_MIN);
		send_item(FUNC_SEARCH, 1);
		send_item(FUNC_REMOVE, 0);
		send_item(FUNC_SEARCH, 0);
		send_item(FUNC_REMOVE, 0);
		send_item(FUNC_REMOVE, 0);
		send_item(FUNC_UNUSED, KEY_MAX);
		send_item(FUNC_REMOVE, KEY_MAX);
		send_item(FUNC_REMOVE, KEY_MIN);
		send_item(FUNC_REMOVE, -1);
	endtask

	// Fill with duplicates, then hit the full table with present and absent keys.
	task automatic test_full_table();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_item(FUNC_INSERT, $signed(KEY_W'((i * 7) % 5)) - 2);
		send_item(FUNC_INSERT, 0);
		send_item(FUNC_INSERT, KEY_MAX);
		send_item(FUNC_UNUSED, 2);
		send_item(FUNC_REMOVE, -2);
		send_item(FUNC_INSERT, KEY_MIN);
		send_item(FUNC_INSERT, KEY_MIN);
	endtask

	// Alternate phases lean toward insert or remove so the count sweeps the range.
	task automatic test_random_mix();
		int      pick;
		bit      filling;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			filling = (p % 2) == 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 19);
				if (pick < (filling ? 12 : 5))
					send_item(FUNC_INSERT, pick_key());
				else if (pick < 16)
					send_item(FUNC_REMOVE, pick_key());
				else if (pick < 19)
					send_item(FUNC_SEARCH, pick_key());
				else
					send_item(FUNC_UNUSED, pick_key());
			end
		end
	endtask

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extremes_and_duplicates();
		test_full_table();
		test_random_mix();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#200000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sorted_list_insert_remove_search.f
rtl/slirs_pkg.sv
rtl/slirs_cell.sv
rtl/sorted_list_insert_remove_search.sv
bench/sorted_list_insert_remove_search_tb.sv
